// ===== hw/rtl/clock_alarm_time_setter_macros.svh =====
// ---------------------------------------------------------------------------
// clock_alarm_time_setter assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef CLOCK_ALARM_TIME_SETTER_MACROS_SVH
`define CLOCK_ALARM_TIME_SETTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every edge outside reset
`define CATS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CATS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CATS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CATS_ASSERT(lbl, clk, rst, prop, msg)
`define CATS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define CATS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/cats_pkg.sv =====
// ---------------------------------------------------------------------------
// cats_pkg
// request and response types, codes and arithmetic helpers of the time setter
// ---------------------------------------------------------------------------
package cats_pkg;

   // opcodes
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // banks
   localparam logic BANK_CLOCK = 1'b0;
   localparam logic BANK_ALARM = 1'b1;

   // key codes
   localparam logic [4:0] KEY_NONE         = 5'd0;
   localparam logic [4:0] KEY_HOURS_UP     = 5'd1;
   localparam logic [4:0] KEY_SECONDS_UP   = 5'd3;
   localparam logic [4:0] KEY_HOURS_DOWN   = 5'd5;
   localparam logic [4:0] KEY_SECONDS_DOWN = 5'd7;

   // field codes
   localparam logic [1:0] FIELD_HOURS   = 2'd0;
   localparam logic [1:0] FIELD_MINUTES = 2'd1;
   localparam logic [1:0] FIELD_SECONDS = 2'd2;
   localparam int         FIELD_COUNT   = 3;

   // limits and reset values
   localparam logic [7:0] HOURS_MAX   = 8'd23;
   localparam logic [7:0] MIN_SEC_MAX = 8'd59;
   localparam logic [7:0] RESET_HOURS = 8'd12;

   typedef logic [7:0] time_value_type;
   typedef time_value_type [FIELD_COUNT-1:0] time_bank_type;

   typedef struct packed {
      logic       opcode;
      logic [4:0] key_code;
      logic       bank;
      logic [7:0] rtc_hours_bcd;
      logic [7:0] rtc_minutes_bcd;
      logic [7:0] rtc_seconds_bcd;
   } req_type;

   typedef struct packed {
      logic [7:0] shown_hours;
      logic [7:0] shown_minutes;
      logic [7:0] shown_seconds;
      logic [1:0] selected_field;
      logic       alarm_match;
      logic [7:0] clock_hours_bcd;
      logic [7:0] clock_minutes_bcd;
      logic [7:0] clock_seconds_bcd;
   } rsp_type;

   // high nibble times ten plus low nibble, at most 165
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      logic [3:0] tens;
      tens = b[7:4];
      return 8'({tens, 3'b000}) + 8'({tens, 1'b0}) + 8'(b[3:0]);
   endfunction

   // tens in the high nibble, units in the low one, truncated to a byte
   function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
      logic [15:0] prod;
      logic [4:0]  quot;
      logic [7:0]  quot_x10;
      logic [7:0]  diff;
      prod     = 16'(v) * 16'd205;   // exact divide by ten below 1029
      quot     = prod[15:11];
      quot_x10 = 8'({quot, 3'b000}) + 8'({quot, 1'b0});
      diff     = v - quot_x10;
      return {quot[3:0], diff[3:0]};
   endfunction

   // wrap to zero once past the limit
   function automatic logic [7:0] step_up(input logic [7:0] v, input logic [7:0] limit);
      logic [8:0] n;
      n = 9'(v) + 9'd1;
      return (n > 9'(limit)) ? 8'd0 : n[7:0];
   endfunction

   // zero wraps to the limit
   function automatic logic [7:0] step_down(input logic [7:0] v, input logic [7:0] limit);
      return (v == 8'd0) ? limit : v - 8'd1;
   endfunction

endpackage

// ===== hw/rtl/cats_chan_if.sv =====
// ---------------------------------------------------------------------------
// cats_chan_if
// valid/ready channel carrying one payload of a given type
// ---------------------------------------------------------------------------
interface cats_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/clock_alarm_time_setter.sv =====
// ---------------------------------------------------------------------------
// clock_alarm_time_setter
// clock and alarm time banks with keypad adjust, rtc load and alarm compare
// ---------------------------------------------------------------------------
// Takes one request per clock cycle unless the response side stalls, and returns
// exactly one response for each: a request lands in an input register, then one
// short pass of logic (key decode, one field step or BCD conversion, bank
// compare and re-encoding) updates the time banks and fills the response
// register in the same edge. The rate is set by that single pass; a stalled
// response holds the input register, and req ready follows rsp ready in the
// same cycle. Both banks reset to 12:00:00, the selection to hours.
`include "clock_alarm_time_setter_macros.svh"

module clock_alarm_time_setter (
   input logic         clock,
   input logic         reset,
   cats_chan_if.sink   req_if,
   cats_chan_if.source rsp_if
);
   import cats_pkg::*;

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type item_ff, item_in;

   // result stage
   logic    out_valid_ff, out_valid_in;
   rsp_type rsp_ff, rsp_in;

   // time state
   time_bank_type clock_bank_ff, clock_bank_in;
   time_bank_type alarm_bank_ff, alarm_bank_in;
   logic [1:0]    field_sel_ff, field_sel_in;
   logic [4:0]    prev_key_ff, prev_key_in;

   logic req_accept;
   logic advance;

   // the held item moves on when the result register is free or being emptied
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_accept = req_if.valid && req_if.ready;

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = rsp_ff;

   always_comb begin
      time_bank_type  next_clock;
      time_bank_type  next_alarm;
      logic [1:0]     next_sel;
      logic [4:0]     next_prev;
      logic           key_hit;
      logic           key_up;
      logic [1:0]     key_field;
      time_value_type limit;
      time_value_type current;
      time_value_type stepped;
      time_bank_type  shown;
      rsp_type        rsp_next;

      next_clock = clock_bank_ff;
      next_alarm = alarm_bank_ff;
      next_sel   = field_sel_ff;
      next_prev  = prev_key_ff;

      // a fresh press of one of the six adjust keys
      key_hit   = (prev_key_ff == KEY_NONE) &&
                  (item_ff.key_code inside {[KEY_HOURS_UP:KEY_SECONDS_UP],
                                            [KEY_HOURS_DOWN:KEY_SECONDS_DOWN]});
      key_up    = item_ff.key_code <= KEY_SECONDS_UP;
      key_field = key_up ? 2'(item_ff.key_code - KEY_HOURS_UP)
                         : 2'(item_ff.key_code - KEY_HOURS_DOWN);
      limit     = (key_field == FIELD_HOURS) ? HOURS_MAX : MIN_SEC_MAX;
      current   = (item_ff.bank == BANK_ALARM) ? alarm_bank_ff[key_field]
                                                : clock_bank_ff[key_field];
      stepped   = key_up ? step_up(current, limit) : step_down(current, limit);

      if (item_ff.opcode == OP_LOAD) begin
         // rtc load fills the clock bank only
         next_clock[FIELD_HOURS]   = bcd_to_bin(item_ff.rtc_hours_bcd);
         next_clock[FIELD_MINUTES] = bcd_to_bin(item_ff.rtc_minutes_bcd);
         next_clock[FIELD_SECONDS] = bcd_to_bin(item_ff.rtc_seconds_bcd);
      end else begin
         next_prev = item_ff.key_code;
         if (key_hit) begin
            next_sel = key_field;
            if (item_ff.bank == BANK_ALARM) begin
               next_alarm[key_field] = stepped;
            end else begin
               next_clock[key_field] = stepped;
            end
         end
      end

      shown = (item_ff.bank == BANK_ALARM) ? next_alarm : next_clock;

      rsp_next.shown_hours       = shown[FIELD_HOURS];
      rsp_next.shown_minutes     = shown[FIELD_MINUTES];
      rsp_next.shown_seconds     = shown[FIELD_SECONDS];
      rsp_next.selected_field    = next_sel;
      rsp_next.alarm_match       = (next_clock == next_alarm);
      rsp_next.clock_hours_bcd   = bin_to_bcd(next_clock[FIELD_HOURS]);
      rsp_next.clock_minutes_bcd = bin_to_bcd(next_clock[FIELD_MINUTES]);
      rsp_next.clock_seconds_bcd = bin_to_bcd(next_clock[FIELD_SECONDS]);

      // state and result move together
      clock_bank_in = advance ? next_clock : clock_bank_ff;
      alarm_bank_in = advance ? next_alarm : alarm_bank_ff;
      field_sel_in  = advance ? next_sel   : field_sel_ff;
      prev_key_in   = advance ? next_prev  : prev_key_ff;
      rsp_in        = advance ? rsp_next   : rsp_ff;

      // handshake bookkeeping
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      item_in = req_accept ? req_if.payload : item_ff;

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         clock_bank_ff <= {8'd0, 8'd0, RESET_HOURS};
         alarm_bank_ff <= {8'd0, 8'd0, RESET_HOURS};
         field_sel_ff  <= FIELD_HOURS;
         prev_key_ff   <= KEY_NONE;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         clock_bank_ff <= clock_bank_in;
         alarm_bank_ff <= alarm_bank_in;
         field_sel_ff  <= field_sel_in;
         prev_key_ff   <= prev_key_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   // a held key leaves the banks and selection as they were
   `CATS_ASSERT_NEXT(a_held_key_idle, clock, reset, advance && item_ff.opcode == OP_KEY && prev_key_ff != KEY_NONE, $stable(clock_bank_ff) && $stable(alarm_bank_ff) && $stable(field_sel_ff), "held key changed time state")

   // an rtc load touches only the clock bank
   `CATS_ASSERT_NEXT(a_load_clock_only, clock, reset, advance && item_ff.opcode == OP_LOAD, $stable(alarm_bank_ff) && $stable(field_sel_ff) && $stable(prev_key_ff), "rtc load changed more than the clock bank")

   // a waiting response agrees with the banks it was built from
   `CATS_ASSERT_NOW(a_match_consistent, clock, reset, out_valid_ff, rsp_ff.alarm_match == (clock_bank_ff == alarm_bank_ff), "alarm match out of step with banks")

   // a stalled response keeps the queued request
   `CATS_ASSERT_NEXT(a_no_drop, clock, reset, in_valid_ff && out_valid_ff && !rsp_if.ready, in_valid_ff, "queued request lost under stall")

endmodule

// ===== tb/clock_alarm_time_setter_test.sv =====
// ---------------------------------------------------------------------------
// clock_alarm_time_setter_test
// drives key scans and rtc loads into the time setter and checks every
// response against a cycle-free model of the two time banks kept here
// ---------------------------------------------------------------------------
module clock_alarm_time_setter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cats_pkg::*;

   // key codes the package leaves unnamed
   localparam logic [4:0] KEY_MINUTES_UP   = 5'd2;
   localparam logic [4:0] KEY_SPARE        = 5'd4;
   localparam logic [4:0] KEY_MINUTES_DOWN = 5'd6;
   localparam logic [4:0] KEY_FIRST_UNUSED = 5'd8;
   localparam logic [4:0] KEY_HIGH_BIT     = 5'd16;
   localparam logic [4:0] KEY_ALL_ONES     = 5'd31;

   localparam int ITEM_TARGET   = 1950;
   localparam int MAX_GAP       = 19;
   localparam int LONG_HOLD     = 300;   // receiver hold-off, well past the block's depth
   localparam int BURST_ITEMS   = 40;    // back-to-back requests during that hold-off
   localparam int STALL_LIMIT   = 3000;  // quiet cycles before the watchdog fires
   localparam int SETTLE_CYCLES = 10;    // response passes the input and result registers after the request

   // -------------------------------------------------------------------------
   // model of the clock and alarm banks plus the queue of awaited responses
   // -------------------------------------------------------------------------
   class time_bank_tracker;
      logic [7:0] store [2][3];   // [bank][field]
      logic [1:0] field_now;
      logic [4:0] last_key;
      rsp_type    awaited [$];
      int         failures;

      function new();
         for (int b = 0; b < 2; b++) begin
            store[b][FIELD_HOURS]   = RESET_HOURS;
            store[b][FIELD_MINUTES] = 8'd0;
            store[b][FIELD_SECONDS] = 8'd0;
         end
         field_now = FIELD_HOURS;
         last_key  = KEY_NONE;
         failures  = 0;
      endfunction

      // bcd byte to binary, bad nibbles go through the same sum
      function logic [7:0] from_bcd(logic [7:0] b);
         return 8'(int'(b[7:4]) * 10 + int'(b[3:0]));
      endfunction

      function logic [7:0] to_bcd(logic [7:0] v);
         return 8'((int'(v) / 10) * 16 + int'(v) % 10);
      endfunction

      function void note_request(req_type r);
         rsp_type    want;
         logic [1:0] f;
         logic [7:0] limit;
         logic [7:0] v;
         if (r.opcode == OP_LOAD) begin
            store[BANK_CLOCK][FIELD_HOURS]   = from_bcd(r.rtc_hours_bcd);
            store[BANK_CLOCK][FIELD_MINUTES] = from_bcd(r.rtc_minutes_bcd);
            store[BANK_CLOCK][FIELD_SECONDS] = from_bcd(r.rtc_seconds_bcd);
         end else begin
            // only a fresh press of one of the six adjust keys does anything
            if (last_key == KEY_NONE && r.key_code >= KEY_HOURS_UP &&
                r.key_code <= KEY_SECONDS_DOWN && r.key_code != KEY_SPARE) begin
               f = (r.key_code >= KEY_HOURS_DOWN) ? 2'(r.key_code - KEY_HOURS_DOWN)
                                                  : 2'(r.key_code - KEY_HOURS_UP);
               limit = (f == FIELD_HOURS) ? HOURS_MAX : MIN_SEC_MAX;
               field_now = f;
               v = store[r.bank][f];
               if (r.key_code <= KEY_SECONDS_UP)
                  store[r.bank][f] = (v >= limit) ? 8'd0 : v + 8'd1;
               else
                  store[r.bank][f] = (v == 8'd0) ? limit : v - 8'd1;
            end
            last_key = r.key_code;
         end
         want.shown_hours       = store[r.bank][FIELD_HOURS];
         want.shown_minutes     = store[r.bank][FIELD_MINUTES];
         want.shown_seconds     = store[r.bank][FIELD_SECONDS];
         want.selected_field    = field_now;
         want.alarm_match       = (store[BANK_CLOCK] == store[BANK_ALARM]);
         want.clock_hours_bcd   = to_bcd(store[BANK_CLOCK][FIELD_HOURS]);
         want.clock_minutes_bcd = to_bcd(store[BANK_CLOCK][FIELD_MINUTES]);
         want.clock_seconds_bcd = to_bcd(store[BANK_CLOCK][FIELD_SECONDS]);
         awaited.push_back(want);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            failures++;
            $display("%0t: response with no request waiting, got %h", $time, got);
            return;
         end
         want = awaited.pop_front();
         compare_field("shown_hours", want.shown_hours, got.shown_hours);
         compare_field("shown_minutes", want.shown_minutes, got.shown_minutes);
         compare_field("shown_seconds", want.shown_seconds, got.shown_seconds);
         compare_field("selected_field", want.selected_field, got.selected_field);
         compare_field("alarm_match", want.alarm_match, got.alarm_match);
         compare_field("clock_hours_bcd", want.clock_hours_bcd, got.clock_hours_bcd);
         compare_field("clock_minutes_bcd", want.clock_minutes_bcd, got.clock_minutes_bcd);
         compare_field("clock_seconds_bcd", want.clock_seconds_bcd, got.clock_seconds_bcd);
      endfunction
   endclass

   logic clock;
   logic reset;

   cats_chan_if #(.payload_type(req_type)) req_if ();
   cats_chan_if #(.payload_type(rsp_type)) rsp_if ();

   clock_alarm_time_setter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   time_bank_tracker tracker = new();

   // shared pacing controls
   bit no_idle           = 0;   // both sides run flat out while set
   bit long_hold_pending = 0;   // receiver takes one long hold-off when it sees this
   int burst_left        = 0;   // sender requests that go out with no gap
   int items_sent        = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // monitor: every handshake is seen at the rising edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (req_if.valid && req_if.ready)
         tracker.note_request(req_if.payload);
      if (rsp_if.valid && rsp_if.ready)
         tracker.check_response(rsp_if.payload);
   end

   // watchdog: any long stretch with no handshake at all ends the run
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // response side: random stall per response, one long hold-off on demand
   // -------------------------------------------------------------------------
   initial begin : receiver
      int stall;
      rsp_if.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            // sender keeps offering, so the block fills and stops taking requests
            long_hold_pending = 0;
            rsp_if.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
               rsp_if.ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_if.ready = 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------

   // offer one request after a random gap and hold it until taken
   task automatic send_item(input req_type item);
      int gap;
      gap = (no_idle || burst_left > 0) ? 0 : $urandom_range(0, MAX_GAP);
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.payload = item;
      req_if.valid   = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   // key scan, rtc bytes carry junk since the block ignores them here
   task automatic send_key(input logic [4:0] key, input logic bank);
      req_type item;
      item.opcode          = OP_KEY;
      item.key_code        = key;
      item.bank            = bank;
      item.rtc_hours_bcd   = 8'($urandom);
      item.rtc_minutes_bcd = 8'($urandom);
      item.rtc_seconds_bcd = 8'($urandom);
      send_item(item);
   endtask

   task automatic send_load(input logic [7:0] h, input logic [7:0] m, input logic [7:0] s,
                            input logic bank);
      req_type item;
      item.opcode          = OP_LOAD;
      item.key_code        = 5'($urandom);
      item.bank            = bank;
      item.rtc_hours_bcd   = h;
      item.rtc_minutes_bcd = m;
      item.rtc_seconds_bcd = s;
      send_item(item);
   endtask

   // stop offering and let every outstanding response come back
   task automatic drain_responses();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int       pick;
      int       scans;
      bit       hold_done;
      bit       drain_done;
      logic [4:0] key;
      req_type  item;

      hold_done  = 0;
      drain_done = 0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: both banks start equal, so the alarm matches at once
      send_key(KEY_NONE, BANK_CLOCK);
      // bad bcd on every byte gives 165, whose re-encoding overflows a byte
      send_load(8'hff, 8'hff, 8'hff, BANK_ALARM);
      // hours above the limit wrap to zero going up
      send_key(KEY_HOURS_UP, BANK_CLOCK);
      send_key(KEY_NONE, BANK_CLOCK);
      // seconds above the limit just count down
      send_key(KEY_SECONDS_DOWN, BANK_CLOCK);
      send_key(KEY_NONE, BANK_ALARM);
      send_key(KEY_HOURS_DOWN, BANK_ALARM);
      // held key does nothing
      send_key(KEY_HOURS_DOWN, BANK_ALARM);
      send_key(KEY_NONE, BANK_ALARM);
      // minutes at zero wrap to 59 going down
      send_key(KEY_MINUTES_DOWN, BANK_ALARM);
      send_key(KEY_NONE, BANK_ALARM);
      send_key(KEY_SECONDS_UP, BANK_ALARM);
      send_key(KEY_NONE, BANK_CLOCK);
      // top of range: 23:59:59 then step past it
      send_load(8'h23, 8'h59, 8'h59, BANK_CLOCK);
      send_key(KEY_HOURS_UP, BANK_CLOCK);
      send_key(KEY_NONE, BANK_CLOCK);
      send_key(KEY_MINUTES_UP, BANK_CLOCK);
      send_key(KEY_NONE, BANK_CLOCK);
      // codes outside the six adjust keys only change the last key
      send_key(KEY_SPARE, BANK_CLOCK);
      send_key(KEY_NONE, BANK_CLOCK);
      send_key(KEY_FIRST_UNUSED, BANK_ALARM);
      send_key(KEY_HIGH_BIT, BANK_CLOCK);
      send_key(KEY_ALL_ONES, BANK_ALARM);
      send_key(KEY_NONE, BANK_CLOCK);
      send_load(8'h00, 8'h00, 8'h00, BANK_CLOCK);

      // random part, mostly press / hold / release sequences
      while (items_sent < ITEM_TARGET) begin
         // every third block of 250 requests runs with no idling on either side
         no_idle = ((items_sent / 250) % 3 == 1);

         if (!hold_done && items_sent >= 500) begin
            hold_done         = 1;
            long_hold_pending = 1;
            burst_left        = BURST_ITEMS;
         end
         if (!drain_done && items_sent >= 1000) begin
            drain_done = 1;
            drain_responses();
         end

         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // a press held for a scan or few, then released
            key   = 5'($urandom_range(KEY_HOURS_UP, KEY_SECONDS_DOWN));
            scans = $urandom_range(1, 3);
            repeat (scans) send_key(key, 1'($urandom));
            scans = $urandom_range(1, 2);
            repeat (scans) send_key(KEY_NONE, 1'($urandom));
         end else if (pick < 82) begin
            send_load(tracker.to_bcd(8'($urandom_range(0, HOURS_MAX))),
                      tracker.to_bcd(8'($urandom_range(0, MIN_SEC_MAX))),
                      tracker.to_bcd(8'($urandom_range(0, MIN_SEC_MAX))),
                      1'($urandom));
         end else if (pick < 87) begin
            // copy the alarm into the clock so that the compare fires
            send_load(tracker.to_bcd(tracker.store[BANK_ALARM][FIELD_HOURS]),
                      tracker.to_bcd(tracker.store[BANK_ALARM][FIELD_MINUTES]),
                      tracker.to_bcd(tracker.store[BANK_ALARM][FIELD_SECONDS]),
                      1'($urandom));
         end else if (pick < 92) begin
            send_load(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
         end else begin
            // noise: anything the fields allow
            item.opcode          = 1'($urandom);
            item.key_code        = 5'($urandom);
            item.bank            = 1'($urandom);
            item.rtc_hours_bcd   = 8'($urandom);
            item.rtc_minutes_bcd = 8'($urandom);
            item.rtc_seconds_bcd = 8'($urandom);
            send_item(item);
         end
      end

      drain_responses();
      // anything arriving now has no request behind it
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (tracker.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== clock_alarm_time_setter.f =====
+incdir+hw/rtl
hw/rtl/cats_pkg.sv
hw/rtl/cats_chan_if.sv
hw/rtl/clock_alarm_time_setter.sv
tb/clock_alarm_time_setter_test.sv
